// ----- sv/depthwise_conv2d_stream_defines.svh -----
// assertion macros for the depthwise convolution stream
// used by modules that carry concurrent checks; no other dependencies
`ifndef DEPTHWISE_CONV2D_STREAM_DEFINES_SVH
`define DEPTHWISE_CONV2D_STREAM_DEFINES_SVH

// same-cycle implication, off during reset
`define DWCONV_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dwconv check failed");

// next-cycle implication, off during reset
`define DWCONV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dwconv check failed");

`endif

// ----- sv/dwconv_pkg.sv -----
// shared types, widths and codes for the depthwise convolution stream
// no dependencies
`default_nettype none
package dwconv_pkg;

  localparam int DEF_MAX_COLS     = 128;
  localparam int DEF_MAX_CHANNELS = 32;
  localparam int DEF_MAX_KERNEL   = 8;
  localparam int DEF_SAMPLE_BITS  = 16;

  localparam int ROW_W     = 12;
  localparam int COL_W     = 8;
  localparam int CHN_W     = 6;
  localparam int KER_W     = 4;
  localparam int SLOT_W    = 4;
  localparam int VALUE_W   = 32;
  localparam int RES_W     = 40;
  localparam int ACC_W     = 48;
  localparam int OCOL_W    = 7;
  localparam int OCH_W     = 5;
  localparam int TAPIN_W   = 6;
  localparam int LCHIN_W   = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 12;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KROWS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KCOLS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RSTEP  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CSTEP  = 3'd6;

  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_BIAS   = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [ROW_W-1:0] rows;
    logic [COL_W-1:0] cols;
    logic [CHN_W-1:0] chs;
    logic [KER_W-1:0] kr;
    logic [KER_W-1:0] kc;
    logic [KER_W-1:0] rs;
    logic [KER_W-1:0] cs;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0]  r;
    logic [COL_W-1:0]  c;
    logic [CHN_W-1:0]  ch;
    logic [SLOT_W-1:0] slot0;
    logic [COL_W-1:0]  c0;
    logic [ROW_W-1:0]  orow;
    logic [COL_W-1:0]  ocol;
    logic              last;
  } job_t;

  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    logic [CHN_W-1:0] ch;
  } guard_t;

  typedef struct packed {
    logic [RES_W-1:0]  result;
    logic [ROW_W-1:0]  orow;
    logic [OCOL_W-1:0] ocol;
    logic [OCH_W-1:0]  ch;
    logic              last;
  } out_t;

endpackage
`default_nettype wire

// ----- sv/dwconv_ram.sv -----
// generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none
module dwconv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- sv/dwconv_fifo.sv -----
// small first-in first-out queue of plain vectors
// no dependencies
`default_nettype none
module dwconv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign dout    = mem[rd_ptr];
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= din;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push_ok, pop_ok})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/dwconv_front.sv -----
// front end: accepts items, fills the stores, tracks frame position, queues windows
// depends on dwconv_pkg
`default_nettype none
module dwconv_front
  import dwconv_pkg::*;
#(
  parameter int MAX_COLS     = DEF_MAX_COLS,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_KERNEL   = DEF_MAX_KERNEL,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
  localparam int SLOT_AW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1,
  localparam int COL_AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int CH_AW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int TAPS    = MAX_KERNEL * MAX_KERNEL,
  localparam int TAP_AW  = (TAPS > 1) ? $clog2(TAPS) : 1,
  localparam int LINE_AW = SLOT_AW + COL_AW + CH_AW,
  localparam int WGT_AW  = CH_AW + TAP_AW
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cfg_t                   cfg,
  input  wire logic                   cfg_write,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [1:0]             operation,
  input  wire logic [TAPIN_W-1:0]     tap_index,
  input  wire logic [LCHIN_W-1:0]     load_channel,
  input  wire logic [VALUE_W-1:0]     value,
  input  wire guard_t                 guard,
  input  wire logic                   jq_full,
  output logic                        job_push,
  output job_t                        job,
  output logic                        line_we,
  output logic [LINE_AW-1:0]          line_waddr,
  output logic [SAMPLE_BITS-1:0]      line_wdata,
  output logic                        wgt_we,
  output logic [WGT_AW-1:0]           wgt_waddr,
  output logic [SAMPLE_BITS-1:0]      wgt_wdata,
  output logic                        bias_we,
  output logic [CH_AW-1:0]            bias_waddr,
  output logic [VALUE_W-1:0]          bias_wdata
);

  op_t               op;
  logic              accept;
  logic              is_load;
  logic              conflict;
  logic              is_sample;
  logic              emit;

  logic [ROW_W-1:0]  r;
  logic [COL_W-1:0]  c;
  logic [CHN_W-1:0]  ch;
  logic [SLOT_W-1:0] slot;
  logic [KER_W-1:0]  rph;
  logic [KER_W-1:0]  cph;
  logic [ROW_W-1:0]  orow;
  logic [COL_W-1:0]  ocol;

  logic [ROW_W-1:0]  r_next;
  logic [COL_W-1:0]  c_next;
  logic [CHN_W-1:0]  ch_next;
  logic [SLOT_W-1:0] slot_next;
  logic [KER_W-1:0]  rph_next;
  logic [KER_W-1:0]  cph_next;
  logic [ROW_W-1:0]  orow_next;
  logic [COL_W-1:0]  ocol_next;

  logic [ROW_W-1:0]  kr_m1;
  logic [COL_W-1:0]  kc_m1;
  logic [SLOT_W:0]   slot_wide;
  logic [SLOT_W:0]   kr_m1_s;

  assign op        = op_t'(operation);
  assign is_load   = (op == OP_WEIGHT) || (op == OP_BIAS);
  assign is_sample = (op == OP_SAMPLE);
  assign conflict  = guard.valid &&
                     ((r != guard.r) || (c < guard.c) || ((c == guard.c) && (ch <= guard.ch)));
  assign full      = jq_full || (is_load && guard.valid) || (is_sample && conflict);
  assign accept    = push && !full;

  assign kr_m1   = ROW_W'(cfg.kr) - 1'b1;
  assign kc_m1   = COL_W'(cfg.kc) - 1'b1;
  assign kr_m1_s = (SLOT_W + 1)'(cfg.kr) - 1'b1;

  // stores
  assign line_we    = accept && is_sample;
  assign line_waddr = {SLOT_AW'(slot), COL_AW'(c), CH_AW'(ch)};
  assign line_wdata = value[SAMPLE_BITS-1:0];

  assign wgt_we     = accept && (op == OP_WEIGHT) && (32'(tap_index) < 32'(TAPS)) &&
                      (32'(load_channel) < 32'(MAX_CHANNELS));
  assign wgt_waddr  = {CH_AW'(load_channel), TAP_AW'(tap_index)};
  assign wgt_wdata  = value[SAMPLE_BITS-1:0];

  assign bias_we    = accept && (op == OP_BIAS) && (32'(load_channel) < 32'(MAX_CHANNELS));
  assign bias_waddr = CH_AW'(load_channel);
  assign bias_wdata = value;

  // window detection
  assign emit = (ROW_W'(cfg.kr) <= cfg.rows) && (COL_W'(cfg.kc) <= cfg.cols) &&
                (r >= kr_m1) && (c >= kc_m1) && (rph == '0) && (cph == '0);
  assign job_push = accept && is_sample && emit;

  always_comb begin
    slot_wide = {1'b0, slot};
    job.r     = r;
    job.c     = c;
    job.ch    = ch;
    job.c0    = c - kc_m1;
    job.orow  = orow;
    job.ocol  = ocol;
    job.last  = ((ROW_W + 1)'(r) + (ROW_W + 1)'(cfg.rs) >= (ROW_W + 1)'(cfg.rows)) &&
                ((COL_W + 1)'(c) + (COL_W + 1)'(cfg.cs) >= (COL_W + 1)'(cfg.cols)) &&
                ((CHN_W + 1)'(ch) + 1'b1 == (CHN_W + 1)'(cfg.chs));
    if (slot_wide >= kr_m1_s) begin
      job.slot0 = SLOT_W'(slot_wide - kr_m1_s);
    end else begin
      job.slot0 = SLOT_W'(slot_wide + (SLOT_W + 1)'(MAX_KERNEL) - kr_m1_s);
    end
  end

  // position advance
  always_comb begin
    r_next    = r;
    c_next    = c;
    ch_next   = ch + 1'b1;
    slot_next = slot;
    rph_next  = rph;
    cph_next  = cph;
    orow_next = orow;
    ocol_next = ocol;
    if ((CHN_W + 1)'(ch) + 1'b1 >= (CHN_W + 1)'(cfg.chs)) begin
      ch_next = '0;
      if ((COL_W + 1)'(c) + 1'b1 >= (COL_W + 1)'(cfg.cols)) begin
        c_next = '0;
        if ((ROW_W + 1)'(r) + 1'b1 >= (ROW_W + 1)'(cfg.rows)) begin
          r_next    = '0;
          slot_next = '0;
        end else begin
          r_next    = r + 1'b1;
          slot_next = (slot == SLOT_W'(MAX_KERNEL - 1)) ? '0 : slot + 1'b1;
        end
        if (r_next <= kr_m1) begin
          rph_next  = '0;
          orow_next = '0;
        end else if (rph + 1'b1 == cfg.rs) begin
          rph_next  = '0;
          orow_next = orow + 1'b1;
        end else begin
          rph_next  = rph + 1'b1;
        end
      end else begin
        c_next = c + 1'b1;
      end
      if (c_next <= kc_m1) begin
        cph_next  = '0;
        ocol_next = '0;
      end else if (cph + 1'b1 == cfg.cs) begin
        cph_next  = '0;
        ocol_next = ocol + 1'b1;
      end else begin
        cph_next  = cph + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      r    <= '0;
      c    <= '0;
      ch   <= '0;
      slot <= '0;
      rph  <= '0;
      cph  <= '0;
      orow <= '0;
      ocol <= '0;
    end else if (accept && is_sample) begin
      r    <= r_next;
      c    <= c_next;
      ch   <= ch_next;
      slot <= slot_next;
      rph  <= rph_next;
      cph  <= cph_next;
      orow <= orow_next;
      ocol <= ocol_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/dwconv_back.sv -----
// back end: walks the taps of one queued window, accumulates, adds bias, saturates
// depends on dwconv_pkg and the assertion macro header
`default_nettype none
`include "depthwise_conv2d_stream_defines.svh"
module dwconv_back
  import dwconv_pkg::*;
#(
  parameter int MAX_COLS     = DEF_MAX_COLS,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_KERNEL   = DEF_MAX_KERNEL,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
  localparam int SLOT_AW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1,
  localparam int COL_AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int CH_AW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int TAPS    = MAX_KERNEL * MAX_KERNEL,
  localparam int TAP_AW  = (TAPS > 1) ? $clog2(TAPS) : 1,
  localparam int LINE_AW = SLOT_AW + COL_AW + CH_AW,
  localparam int WGT_AW  = CH_AW + TAP_AW
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cfg_t                   cfg,
  input  wire logic                   jq_empty,
  input  wire job_t                   jq_head,
  output logic                        jq_pop,
  output guard_t                      cur,
  output logic                        line_re,
  output logic [LINE_AW-1:0]          line_raddr,
  input  wire logic [SAMPLE_BITS-1:0] line_rdata,
  output logic                        wgt_re,
  output logic [WGT_AW-1:0]           wgt_raddr,
  input  wire logic [SAMPLE_BITS-1:0] wgt_rdata,
  output logic                        bias_re,
  output logic [CH_AW-1:0]            bias_raddr,
  input  wire logic [VALUE_W-1:0]     bias_rdata,
  input  wire logic                   res_full,
  output logic                        res_push,
  output out_t                        res
);

  localparam int FRAC = 2 * SAMPLE_BITS - 2;
  localparam int LSH  = (FRAC < 30) ? 30 - FRAC : 0;
  localparam int RSH  = (FRAC > 30) ? FRAC - 30 : 0;
  localparam logic signed [ACC_W-1:0] RES_MAX = ACC_W'((64'sd1 <<< (RES_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] RES_MIN = -ACC_W'(64'sd1 <<< (RES_W - 1));

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    DRAIN,
    DONE
  } state_t;

  state_t                          state;
  job_t                            job;
  logic [KER_W-1:0]                ti;
  logic [KER_W-1:0]                tj;
  logic [SLOT_W-1:0]               slot_i;
  logic [TAP_AW-1:0]               tap;
  logic                            rd_valid;
  logic                            prod_valid;
  logic signed [2*SAMPLE_BITS-1:0] prod;
  logic signed [ACC_W-1:0]         prod_ext;
  logic signed [ACC_W-1:0]         term;
  logic signed [ACC_W-1:0]         acc;
  logic signed [ACC_W-1:0]         sum;
  logic signed [ACC_W-1:0]         bias_ext;
  logic signed [ACC_W-1:0]         sat;
  logic [COL_W-1:0]                col_j;
  logic                            last_tap;

  assign jq_pop     = (state == IDLE) && !jq_empty;
  assign bias_re    = jq_pop;
  assign bias_raddr = CH_AW'(jq_head.ch);

  assign col_j      = job.c0 + COL_W'(tj);
  assign line_re    = (state == RUN);
  assign wgt_re     = (state == RUN);
  assign line_raddr = {SLOT_AW'(slot_i), COL_AW'(col_j), CH_AW'(job.ch)};
  assign wgt_raddr  = {CH_AW'(job.ch), tap};
  assign last_tap   = (ti == cfg.kr - 1'b1) && (tj == cfg.kc - 1'b1);

  assign cur.valid  = (state != IDLE);
  assign cur.r      = job.r;
  assign cur.c      = job.c;
  assign cur.ch     = job.ch;

  assign prod_ext = ACC_W'(prod);
  assign term     = (prod_ext <<< LSH) >>> RSH;
  assign bias_ext = ACC_W'($signed(bias_rdata));
  assign sum      = acc + bias_ext;

  always_comb begin
    if (sum > RES_MAX) begin
      sat = RES_MAX;
    end else if (sum < RES_MIN) begin
      sat = RES_MIN;
    end else begin
      sat = sum;
    end
  end

  assign res_push   = (state == DONE) && !res_full;
  assign res.result = sat[RES_W-1:0];
  assign res.orow   = job.orow;
  assign res.ocol   = OCOL_W'(job.ocol);
  assign res.ch     = OCH_W'(job.ch);
  assign res.last   = job.last;

  always_ff @(posedge clk) begin
    prod <= $signed(line_rdata) * $signed(wgt_rdata);
    if (rst) begin
      state      <= IDLE;
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      rd_valid   <= (state == RUN);
      prod_valid <= rd_valid;
      if (prod_valid) begin
        acc <= acc + term;
      end
      unique case (state)
        IDLE: begin
          if (!jq_empty) begin
            job    <= jq_head;
            ti     <= '0;
            tj     <= '0;
            tap    <= '0;
            slot_i <= jq_head.slot0;
            acc    <= '0;
            state  <= RUN;
          end
        end
        RUN: begin
          tap <= tap + 1'b1;
          if (tj == cfg.kc - 1'b1) begin
            tj     <= '0;
            ti     <= ti + 1'b1;
            slot_i <= (slot_i == SLOT_W'(MAX_KERNEL - 1)) ? '0 : slot_i + 1'b1;
          end else begin
            tj <= tj + 1'b1;
          end
          if (last_tap) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (!rd_valid && !prod_valid) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (!res_full) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `DWCONV_ASSERT_IMPL(a_push_room, clk, rst, res_push, !res_full)
  `DWCONV_ASSERT_IMPL(a_done_drained, clk, rst, state == DONE, !rd_valid && !prod_valid)
  `DWCONV_ASSERT_NEXT(a_pop_starts, clk, rst, jq_pop, state == RUN)
  `DWCONV_ASSERT_NEXT(a_read_then_product, clk, rst, rd_valid, prod_valid)

endmodule
`default_nettype wire

// ----- sv/depthwise_conv2d_stream.sv -----
// Depthwise 2-D convolution over a row-major, channel-interleaved sample stream with no
// padding and configurable strides. Weight and bias loads wait until no window is in
// progress or queued. A sample that completes a stride-aligned window is queued to the
// back end, which reads one kernel tap per cycle from the single read port of the line
// and weight stores. While a window is in progress further samples of the same frame
// row are still taken; a sample on a new row waits until the queued windows are done.
// Results collect in a two-entry queue. Stores hold no reset contents and need no
// clearing pass; configuration writes to an existing register restart the frame
// position.
// depends on dwconv_pkg, dwconv_front, dwconv_back, dwconv_fifo and dwconv_ram
`default_nettype none
module depthwise_conv2d_stream
  import dwconv_pkg::*;
#(
  parameter int MAX_COLS     = DEF_MAX_COLS,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_KERNEL   = DEF_MAX_KERNEL,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [1:0]           operation,
  input  wire logic [TAPIN_W-1:0]   tap_index,
  input  wire logic [LCHIN_W-1:0]   load_channel,
  input  wire logic [VALUE_W-1:0]   value,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [RES_W-1:0]          result,
  output logic [ROW_W-1:0]          out_row,
  output logic [OCOL_W-1:0]         out_col,
  output logic [OCH_W-1:0]          out_channel,
  output logic                      last_of_frame
);

  localparam int SLOT_AW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int COL_AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CH_AW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int TAPS    = MAX_KERNEL * MAX_KERNEL;
  localparam int TAP_AW  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int LINE_AW = SLOT_AW + COL_AW + CH_AW;
  localparam int WGT_AW  = CH_AW + TAP_AW;

  logic [ROW_W-1:0] reg_rows;
  logic [COL_W-1:0] reg_cols;
  logic [CHN_W-1:0] reg_chs;
  logic [KER_W-1:0] reg_kr;
  logic [KER_W-1:0] reg_kc;
  logic [KER_W-1:0] reg_rs;
  logic [KER_W-1:0] reg_cs;
  cfg_t             cfg;
  logic             cfg_hit;

  // only writes to an existing register restart the frame
  assign cfg_hit = cfg_write && (cfg_index <= REG_CSTEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_rows <= ROW_W'(32);
      reg_cols <= COL_W'(32);
      reg_chs  <= CHN_W'(1);
      reg_kr   <= KER_W'(3);
      reg_kc   <= KER_W'(3);
      reg_rs   <= KER_W'(1);
      reg_cs   <= KER_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROWS:  reg_rows <= cfg_data[ROW_W-1:0];
        REG_COLS:  reg_cols <= cfg_data[COL_W-1:0];
        REG_CHS:   reg_chs  <= cfg_data[CHN_W-1:0];
        REG_KROWS: reg_kr   <= cfg_data[KER_W-1:0];
        REG_KCOLS: reg_kc   <= cfg_data[KER_W-1:0];
        REG_RSTEP: reg_rs   <= cfg_data[KER_W-1:0];
        REG_CSTEP: reg_cs   <= cfg_data[KER_W-1:0];
        default:   reg_rows <= reg_rows;
      endcase
    end
  end

  // clamp to the supported ranges
  always_comb begin
    cfg.rows = (reg_rows == '0) ? ROW_W'(1) : reg_rows;
    if (reg_cols == '0) begin
      cfg.cols = COL_W'(1);
    end else if (32'(reg_cols) > 32'(MAX_COLS)) begin
      cfg.cols = COL_W'(MAX_COLS);
    end else begin
      cfg.cols = reg_cols;
    end
    if (reg_chs == '0) begin
      cfg.chs = CHN_W'(1);
    end else if (32'(reg_chs) > 32'(MAX_CHANNELS)) begin
      cfg.chs = CHN_W'(MAX_CHANNELS);
    end else begin
      cfg.chs = reg_chs;
    end
    if (reg_kr == '0) begin
      cfg.kr = KER_W'(1);
    end else if (32'(reg_kr) > 32'(MAX_KERNEL)) begin
      cfg.kr = KER_W'(MAX_KERNEL);
    end else begin
      cfg.kr = reg_kr;
    end
    if (reg_kc == '0) begin
      cfg.kc = KER_W'(1);
    end else if (32'(reg_kc) > 32'(MAX_KERNEL)) begin
      cfg.kc = KER_W'(MAX_KERNEL);
    end else begin
      cfg.kc = reg_kc;
    end
    cfg.rs = (reg_rs == '0) ? KER_W'(1) : reg_rs;
    cfg.cs = (reg_cs == '0) ? KER_W'(1) : reg_cs;
  end

  logic                   jq_full;
  logic                   jq_empty;
  logic                   jq_push;
  logic                   jq_pop;
  job_t                   job_in;
  job_t                   jq_head;
  guard_t                 cur;
  guard_t                 guard;

  logic                   line_we;
  logic [LINE_AW-1:0]     line_waddr;
  logic [SAMPLE_BITS-1:0] line_wdata;
  logic                   line_re;
  logic [LINE_AW-1:0]     line_raddr;
  logic [SAMPLE_BITS-1:0] line_rdata;
  logic                   wgt_we;
  logic [WGT_AW-1:0]      wgt_waddr;
  logic [SAMPLE_BITS-1:0] wgt_wdata;
  logic                   wgt_re;
  logic [WGT_AW-1:0]      wgt_raddr;
  logic [SAMPLE_BITS-1:0] wgt_rdata;
  logic                   bias_we;
  logic [CH_AW-1:0]       bias_waddr;
  logic [VALUE_W-1:0]     bias_wdata;
  logic                   bias_re;
  logic [CH_AW-1:0]       bias_raddr;
  logic [VALUE_W-1:0]     bias_rdata;

  logic                   res_full;
  logic                   res_push;
  out_t                   res_in;
  out_t                   res_out;

  // oldest window still reading the line store
  always_comb begin
    if (cur.valid) begin
      guard = cur;
    end else begin
      guard.valid = !jq_empty;
      guard.r     = jq_head.r;
      guard.c     = jq_head.c;
      guard.ch    = jq_head.ch;
    end
  end

  dwconv_front #(
    .MAX_COLS     (MAX_COLS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_KERNEL   (MAX_KERNEL),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cfg_write    (cfg_hit),
    .push         (push),
    .full         (full),
    .operation    (operation),
    .tap_index    (tap_index),
    .load_channel (load_channel),
    .value        (value),
    .guard        (guard),
    .jq_full      (jq_full),
    .job_push     (jq_push),
    .job          (job_in),
    .line_we      (line_we),
    .line_waddr   (line_waddr),
    .line_wdata   (line_wdata),
    .wgt_we       (wgt_we),
    .wgt_waddr    (wgt_waddr),
    .wgt_wdata    (wgt_wdata),
    .bias_we      (bias_we),
    .bias_waddr   (bias_waddr),
    .bias_wdata   (bias_wdata)
  );

  dwconv_fifo #(
    .WIDTH (($bits(job_t))),
    .DEPTH (2)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (jq_push),
    .din   (job_in),
    .full  (jq_full),
    .pop   (jq_pop),
    .dout  (jq_head),
    .empty (jq_empty)
  );

  dwconv_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (2 ** LINE_AW)
  ) u_line_store (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .re    (line_re),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  dwconv_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (2 ** WGT_AW)
  ) u_weight_store (
    .clk   (clk),
    .we    (wgt_we),
    .waddr (wgt_waddr),
    .wdata (wgt_wdata),
    .re    (wgt_re),
    .raddr (wgt_raddr),
    .rdata (wgt_rdata)
  );

  dwconv_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (2 ** CH_AW)
  ) u_bias_store (
    .clk   (clk),
    .we    (bias_we),
    .waddr (bias_waddr),
    .wdata (bias_wdata),
    .re    (bias_re),
    .raddr (bias_raddr),
    .rdata (bias_rdata)
  );

  dwconv_back #(
    .MAX_COLS     (MAX_COLS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_KERNEL   (MAX_KERNEL),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .jq_empty   (jq_empty),
    .jq_head    (jq_head),
    .jq_pop     (jq_pop),
    .cur        (cur),
    .line_re    (line_re),
    .line_raddr (line_raddr),
    .line_rdata (line_rdata),
    .wgt_re     (wgt_re),
    .wgt_raddr  (wgt_raddr),
    .wgt_rdata  (wgt_rdata),
    .bias_re    (bias_re),
    .bias_raddr (bias_raddr),
    .bias_rdata (bias_rdata),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in)
  );

  dwconv_fifo #(
    .WIDTH (($bits(out_t))),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign result        = res_out.result;
  assign out_row       = res_out.orow;
  assign out_col       = res_out.ocol;
  assign out_channel   = res_out.ch;
  assign last_of_frame = res_out.last;

endmodule
`default_nettype wire

// ----- verif/dwconv_checker.sv -----
// result checker for the depthwise convolution stream: follows the config, input and
// result ports, predicts every output transaction and compares it; needs dwconv_pkg only
`default_nettype none
module dwconv_checker
  import dwconv_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 push,
  input  wire logic                 full,
  input  wire logic [1:0]           operation,
  input  wire logic [TAPIN_W-1:0]   tap_index,
  input  wire logic [LCHIN_W-1:0]   load_channel,
  input  wire logic [VALUE_W-1:0]   value,
  input  wire logic                 empty,
  input  wire logic                 pop,
  input  wire logic [RES_W-1:0]     result,
  input  wire logic [ROW_W-1:0]     out_row,
  input  wire logic [OCOL_W-1:0]    out_col,
  input  wire logic [OCH_W-1:0]     out_channel,
  input  wire logic                 last_of_frame,
  output int                        errors,
  output int                        pending,
  output int                        outputs_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NK = DEF_MAX_KERNEL;
  localparam int NC = DEF_MAX_COLS;
  localparam int NCH = DEF_MAX_CHANNELS;

  logic signed [15:0] line_mem [NK][NC][NCH];
  logic signed [15:0] kernel_mem [NCH][NK*NK];
  logic signed [31:0] bias_mem [NCH];
  cfg_t regs;
  int unsigned row_pos, col_pos, chan_pos;
  out_t conv_q[$];

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic take_sample(logic [VALUE_W-1:0] v);
    int unsigned rows, cols, chs, kr, kc, rs, cs, r, c, ch, r0, c0, orow, ocol;
    longint acc;
    out_t o;
    rows = clamp(regs.rows, 1, 4095);
    cols = clamp(regs.cols, 1, NC);
    chs  = clamp(regs.chs, 1, NCH);
    kr   = clamp(regs.kr, 1, NK);
    kc   = clamp(regs.kc, 1, NK);
    rs   = clamp(regs.rs, 1, 15);
    cs   = clamp(regs.cs, 1, 15);
    r = row_pos; c = col_pos; ch = chan_pos;
    if (r >= rows || c >= cols || ch >= chs) begin
      r = 0; c = 0; ch = 0;
    end
    line_mem[r % NK][c][ch] = v[15:0];
    if (kr <= rows && kc <= cols && r + 1 >= kr && c + 1 >= kc &&
        (r + 1 - kr) % rs == 0 && (c + 1 - kc) % cs == 0) begin
      r0 = r + 1 - kr; c0 = c + 1 - kc;
      orow = r0 / rs; ocol = c0 / cs;
      acc = 0;
      for (int i = 0; i < kr; i++)
        for (int j = 0; j < kc; j++)
          acc += longint'(line_mem[(r0 + i) % NK][c0 + j][ch]) *
                 longint'(kernel_mem[ch][i * kc + j]);
      acc += longint'(bias_mem[ch]);
      if (acc >= (64'sd1 <<< 39)) acc = (64'sd1 <<< 39) - 1;
      if (acc < -(64'sd1 <<< 39)) acc = -(64'sd1 <<< 39);
      o.result = acc[RES_W-1:0];
      o.orow = orow[ROW_W-1:0];
      o.ocol = ocol[OCOL_W-1:0];
      o.ch = ch[OCH_W-1:0];
      o.last = (orow == (rows - kr) / rs && ocol == (cols - kc) / cs && ch + 1 == chs);
      conv_q.push_back(o);
    end
    ch++;
    if (ch >= chs) begin
      ch = 0; c++;
      if (c >= cols) begin
        c = 0; r++;
        if (r >= rows) r = 0;
      end
    end
    row_pos = r; col_pos = c; chan_pos = ch;
  endtask

  always @(posedge clk) begin
    out_t exp_o;
    if (rst) begin
      regs = '{rows: 32, cols: 32, chs: 1, kr: 3, kc: 3, rs: 1, cs: 1};
      row_pos = 0; col_pos = 0; chan_pos = 0;
      conv_q.delete();
      errors <= 0;
      outputs_seen <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ROWS:  regs.rows = cfg_data[ROW_W-1:0];
          REG_COLS:  regs.cols = cfg_data[COL_W-1:0];
          REG_CHS:   regs.chs  = cfg_data[CHN_W-1:0];
          REG_KROWS: regs.kr   = cfg_data[KER_W-1:0];
          REG_KCOLS: regs.kc   = cfg_data[KER_W-1:0];
          REG_RSTEP: regs.rs   = cfg_data[KER_W-1:0];
          REG_CSTEP: regs.cs   = cfg_data[KER_W-1:0];
          default: ;
        endcase
        if (cfg_index <= REG_CSTEP) begin
          row_pos = 0; col_pos = 0; chan_pos = 0;
        end
      end
      if (pop && !empty) begin
        outputs_seen <= outputs_seen + 1;
        if (conv_q.size() == 0) begin
          if (errors < 10) $display("unexpected result transaction %h", result);
          errors <= errors + 1;
        end else begin
          exp_o = conv_q.pop_front();
          if (exp_o.result !== result || exp_o.orow !== out_row || exp_o.ocol !== out_col ||
              exp_o.ch !== out_channel || exp_o.last !== last_of_frame) begin
            if (errors < 10)
              $display("mismatch: exp %h r%0d c%0d ch%0d l%b, got %h r%0d c%0d ch%0d l%b",
                       exp_o.result, exp_o.orow, exp_o.ocol, exp_o.ch, exp_o.last,
                       result, out_row, out_col, out_channel, last_of_frame);
            errors <= errors + 1;
          end
        end
      end
      if (push && !full) begin
        case (op_t'(operation))
          OP_WEIGHT: kernel_mem[load_channel][tap_index] = value[15:0];
          OP_BIAS:   bias_mem[load_channel] = value;
          OP_SAMPLE: take_sample(value);
          default: ;
        endcase
      end
    end
    pending <= conv_q.size();
  end
endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// top of the depthwise convolution stream testbench: clock, reset, stimulus and verdict
// depends on dwconv_pkg, depthwise_conv2d_stream and dwconv_checker
`default_nettype none
module tb;
  import dwconv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst = 1;
  logic cfg_write = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic push = 0, pop = 0;
  logic [1:0] operation = '0;
  logic [TAPIN_W-1:0] tap_index = '0;
  logic [LCHIN_W-1:0] load_channel = '0;
  logic [VALUE_W-1:0] value = '0;
  logic full, empty, last_of_frame;
  logic [RES_W-1:0] result;
  logic [ROW_W-1:0] out_row;
  logic [OCOL_W-1:0] out_col;
  logic [OCH_W-1:0] out_channel;
  int errors, pending, outputs_seen;
  int tx_idle = 34, rx_idle = 47;
  int samples_sent = 0, setups = 0;

  always #5 clk = ~clk;

  depthwise_conv2d_stream u_top (.*);
  dwconv_checker u_chk (.*);

  always @(posedge clk) pop <= ($urandom_range(99) >= rx_idle);

  task automatic send(op_t op, int tap, int lch, logic [31:0] v);
    while ($urandom_range(99) < tx_idle) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    operation <= op;
    tap_index <= tap[TAPIN_W-1:0];
    load_channel <= lch[LCHIN_W-1:0];
    value <= v;
    @(negedge clk);
    while (full) @(negedge clk);
    @(posedge clk);
    if (op == OP_SAMPLE) samples_sent++;
  endtask

  task automatic drain();
    push <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (100) @(posedge clk);
  endtask

  // expects kernel size within MAX_KERNEL so the matching taps get loaded
  task automatic setup(int rows, int cols, int chs, int kr, int kc, int rs, int cs);
    int vals[7];
    vals = '{rows, cols, chs, kr, kc, rs, cs};
    drain();
    for (int i = 0; i < 7; i++) begin
      cfg_write <= 1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= vals[i][CFG_W-1:0];
      @(posedge clk);
    end
    cfg_write <= 0;
    setups++;
    for (int ch = 0; ch < (chs > 32 ? 32 : chs); ch++) begin
      for (int t = 0; t < (kr > 8 ? 8 : kr) * (kc > 8 ? 8 : kc); t++)
        send(OP_WEIGHT, t, ch, $urandom());
      send(OP_BIAS, 0, ch, $urandom());
    end
  endtask

  initial begin
    int rows, cols, chs, kr, kc, n;
    repeat (7) @(posedge clk);
    rst <= 0;
    // directed: extreme operands on a single 3x3 window
    setup(3, 3, 1, 3, 3, 1, 1);
    send(OP_WEIGHT, 0, 0, 32'h0000_8000);
    send(OP_WEIGHT, 8, 0, 32'hffff_7fff);
    send(OP_BIAS, 0, 0, 32'h8000_0000);
    send(OP_NONE, 63, 31, 32'hffff_ffff);
    for (int i = 0; i < 9; i++) send(OP_SAMPLE, 0, 0, i[0] ? 32'h7fff : 32'hffff_8000);
    send(OP_BIAS, 0, 0, 32'h7fff_ffff);
    for (int i = 0; i < 9; i++) send(OP_SAMPLE, 0, 0, 32'h8000);
    // kernel larger than frame
    setup(2, 2, 1, 3, 3, 1, 1);
    for (int i = 0; i < 4; i++) send(OP_SAMPLE, 0, 0, $urandom());
    // tallest frame, biggest kernel, stride equal to the kernel
    setup(4095, 8, 1, 8, 8, 8, 8);
    for (int i = 0; i < 64; i++) send(OP_SAMPLE, 0, 0, $urandom());
    // out-of-range values clamp: rows 0, cols 255, channels 63, strides 0
    setup(0, 255, 63, 1, 1, 0, 0);
    for (int i = 0; i < 64; i++) send(OP_SAMPLE, 0, 0, $urandom());
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin tx_idle = 47; rx_idle = 34; end
      if (ph == 6) begin tx_idle = 0; rx_idle = 0; end
      rows = $urandom_range(1, 6);
      cols = $urandom_range(1, 10);
      chs = $urandom_range(1, 3);
      kr = $urandom_range(1, rows + 1 > 4 ? 4 : rows + 1);
      kc = $urandom_range(1, cols + 1 > 4 ? 4 : cols + 1);
      setup(rows, cols, chs, kr, kc, $urandom_range(1, 3), $urandom_range(1, 3));
      n = rows * cols * chs * 3 / 2;
      if (n > 30) n = 30;
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(19))
          0: send(OP_NONE, $urandom_range(63), $urandom_range(31), $urandom());
          1: send(OP_BIAS, 0, $urandom_range(chs - 1), $urandom());
          default: send(OP_SAMPLE, $urandom_range(63), $urandom_range(31), $urandom());
        endcase
        if (ph == 4 && i == n / 2) drain();
      end
    end
    drain();
    $display("covered %0d samples over %0d register settings, %0d results checked",
             samples_sent, setups, outputs_seen);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+sv
sv/dwconv_pkg.sv
sv/dwconv_ram.sv
sv/dwconv_fifo.sv
sv/dwconv_front.sv
sv/dwconv_back.sv
sv/depthwise_conv2d_stream.sv
verif/dwconv_checker.sv
verif/tb.sv
